// ===== hw/rtl/rmip_pkg.sv =====
// Shared types, constants and register codes for the rotated maximum
// intensity projection block. Depends on nothing; all files but the RAM import it.
package rmip_pkg;

	localparam int MAX_DIM_DEF = 256;
	localparam int CFG_W       = 18;
	localparam int CFG_IDX_W   = 3;
	localparam int PIX_W       = 16;
	localparam int QUOT_W      = 8;
	localparam int NUM_W       = 28;
	localparam int DEN_W       = 19;
	localparam logic [7:0] FULL_SCALE = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VIEW_WIDTH,
		REG_VIEW_HEIGHT,
		REG_VIEW_DEPTH,
		REG_COS_ANGLE,
		REG_SIN_ANGLE,
		REG_LEVEL_CENTER,
		REG_WINDOW_WIDTH,
		REG_CHANNEL_MODE
	} cfg_reg_t;

	typedef enum logic {
		OP_VOXEL = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_NU,
		ST_COL,
		ST_READ,
		ST_CMP,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  voxel_x;
		logic [7:0]  voxel_y;
		logic [7:0]  voxel_z;
		logic [15:0] intensity;
	} in_t;

	typedef struct packed {
		logic [7:0] pixel_column;
		logic [7:0] pixel_row;
		logic [1:0] pixel_channel;
		logic [7:0] pixel_value;
	} out_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] numer;
		logic [DEN_W-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== hw/rtl/rmip_ram.sv =====
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
module rmip_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== hw/rtl/rmip_div.sv =====
// Restoring divider, one quotient bit per cycle, for the level/window map.
// Depends on rmip_pkg.
module rmip_div
	import rmip_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [NUM_W-1:0]          rem_q;
	logic [NUM_W-1:0]          dsh_q;
	logic [QUOT_W-1:0]         quot_q;
	logic [$clog2(QUOT_W)-1:0] cnt_q;
	logic                      run_q;
	logic                      done_q;
	logic                      ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(QUOT_W))'(QUOT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.numer;
			dsh_q  <= NUM_W'({req.denom, {(QUOT_W-1){1'b0}}});
			quot_q <= '0;
		end else if (run_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[QUOT_W-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ===== hw/rtl/rotated_max_intensity_projection.sv =====
// Top level of the rotated maximum intensity projection: sequencer, column
// math and maximum store. Depends on rmip_pkg, rmip_ram and rmip_div.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_item (in_t)
//   out      output     out_valid/out_stall  out_item (out_t)
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// From one accepted item to the next, a voxel passes the nu, column and read
// states, ending there if it misses the image or after the compare state if it
// does not beat the stored maximum; else it goes to the output state, by way of
// the eight step divider in the divide state unless it saturates to 0 or 255.
// Store read, compare and write share one RAM port. A clear item, and reset,
// zero all MAX_DIM*MAX_DIM words and take no item. A finished item waits in the
// output register, and the block moves on unless that register is still full.
module rotated_max_intensity_projection
	import rmip_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_t                  in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_t                 out_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);

	// Configuration registers.
	logic [8:0]         width_q, height_q, depth_q;
	logic signed [15:0] cos_q, sin_q;
	logic [15:0]        level_q;
	logic [17:0]        window_q;
	logic [1:0]         mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 9'd256;
			height_q <= 9'd256;
			depth_q  <= 9'd256;
			cos_q    <= 16'sd0;
			sin_q    <= 16'sd16384;
			level_q  <= 16'd32768;
			window_q <= 18'd65536;
			mode_q   <= 2'd0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_VIEW_WIDTH:   width_q  <= cfg_data[8:0];
				REG_VIEW_HEIGHT:  height_q <= cfg_data[8:0];
				REG_VIEW_DEPTH:   depth_q  <= cfg_data[8:0];
				REG_COS_ANGLE:    cos_q    <= $signed(cfg_data[15:0]);
				REG_SIN_ANGLE:    sin_q    <= $signed(cfg_data[15:0]);
				REG_LEVEL_CENTER: level_q  <= cfg_data[15:0];
				REG_WINDOW_WIDTH: window_q <= cfg_data[17:0];
				REG_CHANNEL_MODE: mode_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	in_t    item_q;
	logic [ADDR_W-1:0]  clr_cnt_q;
	logic signed [28:0] t_q;
	logic signed [30:0] s_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [7:0]         col_q;
	logic [7:0]         val_q;
	out_t               out_q;
	logic               out_valid_q;

	// Column math.
	logic signed [10:0] dx, dz;
	logic signed [26:0] prod_x, prod_z;
	logic signed [28:0] t_d;
	logic [28:0]        t_abs;
	logic [14:0]        nu;
	logic signed [30:0] s_d;
	logic [30:0]        s_abs, s_rnd;
	logic [16:0]        u;
	logic               u_ok, y_ok;
	logic [ADDR_W-1:0]  addr_d;

	assign dx     = $signed({2'b00, item_q.voxel_x, 1'b0} - {2'b00, width_q});
	assign dz     = $signed({2'b00, item_q.voxel_z, 1'b0} - {2'b00, depth_q});
	assign prod_x = dx * sin_q;
	assign prod_z = dz * cos_q;
	assign t_d    = $signed({{2{prod_x[26]}}, prod_x} + {6'b0, width_q, 14'b0});

	// Division by 2^15 truncates toward zero.
	assign t_abs = t_q[28] ? 29'(-t_q) : 29'(t_q);
	assign nu    = t_q[28] ? 15'(-{1'b0, t_abs[28:15]}) : {1'b0, t_abs[28:15]};
	assign s_d   = $signed({{4{prod_z[26]}}, prod_z} + {nu[14], nu, 15'b0});

	// Halves round away from zero.
	assign s_abs = s_q[30] ? 31'(-s_q) : 31'(s_q);
	assign s_rnd = s_abs + 31'd16384;
	assign u     = s_q[30] ? 17'(-{1'b0, s_rnd[30:15]}) : {1'b0, s_rnd[30:15]};
	assign u_ok  = !u[16] && (u[15:0] < {7'b0, width_q}) && (u[15:0] < 16'(MAX_DIM));
	assign y_ok  = ({1'b0, item_q.voxel_y} < height_q) &&
		(11'(item_q.voxel_y) < 11'(MAX_DIM));
	assign addr_d = ADDR_W'(32'(item_q.voxel_y) * MAX_DIM + 32'(u[15:0]));

	// Maximum store.
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [PIX_W-1:0]  ram_wdata, ram_rdata;

	rmip_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Level/window map, all in units of 2^-17.
	logic [16:0]       vv;
	logic signed [19:0] lo;
	logic [19:0]       hi;
	logic [18:0]       n;
	logic              below, above, larger, sat;
	logic [7:0]        sat_val;
	logic              div_start;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign vv     = {item_q.intensity, 1'b0};
	assign lo     = $signed({3'b0, level_q, 1'b0} - {2'b0, window_q});
	assign hi     = {3'b0, level_q, 1'b0} + {2'b0, window_q};
	assign below  = $signed({3'b0, vv}) < lo;
	assign above  = {3'b0, vv} > hi;
	assign n      = 19'({3'b0, vv} - lo);
	assign larger = item_q.intensity > ram_rdata;
	assign sat    = below || above || (window_q == '0);
	assign sat_val = above ? FULL_SCALE : 8'd0;

	assign div_req.start = div_start;
	assign div_req.numer = NUM_W'({n, 8'b0}) - NUM_W'(n) + NUM_W'(window_q);
	assign div_req.denom = {window_q, 1'b0};

	rmip_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_cnt_q == ADDR_W'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (op_t'(in_item.op) == OP_CLEAR) ? ST_CLEAR : ST_NU;
				end
			end
			ST_NU:   state_d = ST_COL;
			ST_COL:  state_d = ST_READ;
			ST_READ: state_d = (u_ok && y_ok) ? ST_CMP : ST_IDLE;
			ST_CMP: begin
				if (!larger) begin
					state_d = ST_IDLE;
				end else begin
					state_d = sat ? ST_OUT : ST_DIV;
				end
			end
			ST_DIV:  if (div_rsp.done) state_d = ST_OUT;
			ST_OUT:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_addr  = addr_q;
		ram_wdata = item_q.intensity;
		div_start = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_cnt_q;
				ram_wdata = '0;
			end
			ST_IDLE: in_stall = 1'b0;
			ST_READ: ram_addr = addr_d;
			ST_CMP: begin
				ram_we    = larger;
				div_start = larger && !sat;
			end
			ST_NU, ST_COL, ST_DIV, ST_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end else begin
				clr_cnt_q <= '0;
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			item_q <= in_item;
		end
		if (state_q == ST_NU) begin
			t_q <= t_d;
		end
		if (state_q == ST_COL) begin
			s_q <= s_d;
		end
		if (state_q == ST_READ) begin
			addr_q <= addr_d;
			col_q  <= u[7:0];
		end
		if (state_q == ST_CMP) begin
			val_q <= sat_val;
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			val_q <= div_rsp.quot;
		end
		if (state_q == ST_OUT && out_free) begin
			out_q.pixel_column  <= col_q;
			out_q.pixel_row     <= 8'(height_q - 9'd1 - {1'b0, item_q.voxel_y});
			out_q.pixel_channel <= mode_q;
			out_q.pixel_value   <= val_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== hw/rtl/rmip_checker.sv =====
// Port-level checks for the rotated maximum intensity projection, bound to
// the top level. Depends on rmip_pkg and rotated_max_intensity_projection.
module rmip_checker
	import rmip_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input in_t  in_item,
	input logic out_valid,
	input logic out_stall,
	input out_t out_item
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("output item changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken while the previous one is still in work");

	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.op == OP_CLEAR |=> in_stall ##1 in_stall)
		else $error("item taken during the store clearing sweep");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while the block was idle");

endmodule

bind rotated_max_intensity_projection rmip_checker u_rmip_checker (.*);

// ===== dv/rotated_max_intensity_projection_tb.sv =====
// Self-checking testbench for rotated_max_intensity_projection: a directed pass, then
// random voxel streams under three idle patterns, checked against an in-bench predictor.
// Depends on rmip_pkg and the block's RTL only.
module rotated_max_intensity_projection_tb;
	import rmip_pkg::*;

	localparam int STORE_DIM = 256;
	localparam int HALF_Q15  = 16384;
	localparam int ONE_Q15   = 32768;
	localparam int WDOG_LIMIT = 300000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_t                  in_item = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_t                 out_item;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	rotated_max_intensity_projection i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: register copies and the maximum store.
	longint view_w, view_h, view_d, cos_q, sin_q, level_q, window_q, chan_mode;
	logic [15:0] max_store [STORE_DIM*STORE_DIM];
	out_t pending_pixels [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int error_count = 0;
	int items_sent = 0;
	int pixels_seen = 0;
	int clears_sent = 0;
	int cfg_writes = 0;
	int wdog_count = 0;

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic void reset_predictor();
		view_w = 256; view_h = 256; view_d = 256;
		cos_q = 0; sin_q = 16384;
		level_q = 32768; window_q = 65536; chan_mode = 0;
		foreach (max_store[i]) max_store[i] = '0;
	endfunction

	function automatic longint display_value(longint v);
		longint vv, lo, hi, d;
		vv = 2 * v;
		lo = 2 * level_q - window_q;
		hi = 2 * level_q + window_q;
		d = 2 * window_q;
		if (vv < lo) return 0;
		if (vv > hi) return 255;
		if (d == 0) return 0;
		return (2 * 255 * (vv - lo) + d) / (2 * d);
	endfunction

	// Returns 1 and the expected pixel write when the item causes one.
	function automatic bit project_voxel(input in_t it, output out_t px);
		longint x, y, z, t, nu, s, u;
		int addr;
		px = '0;
		if (it.op == OP_CLEAR) begin
			foreach (max_store[i]) max_store[i] = '0;
			return 0;
		end
		x = it.voxel_x; y = it.voxel_y; z = it.voxel_z;
		t = (2 * x - view_w) * sin_q + view_w * HALF_Q15;
		nu = t / ONE_Q15;
		s = (2 * z - view_d) * cos_q + nu * ONE_Q15;
		if (s >= 0)
			u = (s + HALF_Q15) / ONE_Q15;
		else
			u = -((-s + HALF_Q15) / ONE_Q15);
		if (u < 0 || u >= view_w || u >= STORE_DIM) return 0;
		if (y >= view_h || y >= STORE_DIM) return 0;
		addr = int'(u + y * STORE_DIM);
		if (it.intensity <= max_store[addr]) return 0;
		max_store[addr] = it.intensity;
		px.pixel_column  = u[7:0];
		px.pixel_row     = 8'(view_h - 1 - y);
		px.pixel_channel = chan_mode[1:0];
		px.pixel_value   = 8'(display_value(it.intensity));
		return 1;
	endfunction

	// Drops valid at the falling edge after acceptance; the block is busy then anyway.
	task automatic send_item(input in_t it);
		out_t px;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (it.op == OP_CLEAR) clears_sent++;
		if (project_voxel(it, px)) pending_pixels.insert(pending_pixels.size(), px);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic send_voxel(input int x, input int y, input int z, input int v);
		in_t it;
		it.op = OP_VOXEL;
		it.voxel_x = x[7:0]; it.voxel_y = y[7:0]; it.voxel_z = z[7:0];
		it.intensity = v[15:0];
		send_item(it);
	endtask

	task automatic send_clear();
		in_t it;
		it = in_t'($urandom());
		it.op = OP_CLEAR;
		send_item(it);
	endtask

	// Drops valid, drains expected pixels and lets any trailing work finish.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input longint value);
		logic [CFG_W-1:0] v;
		v = value[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
		case (idx)
			REG_VIEW_WIDTH:   view_w = v[8:0];
			REG_VIEW_HEIGHT:  view_h = v[8:0];
			REG_VIEW_DEPTH:   view_d = v[8:0];
			REG_COS_ANGLE:    cos_q = longint'($signed(v[15:0]));
			REG_SIN_ANGLE:    sin_q = longint'($signed(v[15:0]));
			REG_LEVEL_CENTER: level_q = v[15:0];
			REG_WINDOW_WIDTH: window_q = v[17:0];
			REG_CHANNEL_MODE: chan_mode = v[1:0];
			default: ;
		endcase
	endtask

	task automatic pick_config();
		int sel;
		sel = $urandom_range(9);
		write_reg(REG_VIEW_WIDTH, sel == 0 ? 1 : sel == 1 ? 511 : sel == 2 ? 256
			: $urandom_range(2, 256));
		sel = $urandom_range(9);
		write_reg(REG_VIEW_HEIGHT, sel == 0 ? 1 : sel == 1 ? 511 : sel == 2 ? 256
			: $urandom_range(2, 256));
		sel = $urandom_range(9);
		write_reg(REG_VIEW_DEPTH, sel == 0 ? 1 : sel == 1 ? 511 : $urandom_range(1, 256));
		sel = $urandom_range(9);
		write_reg(REG_COS_ANGLE, sel == 0 ? -16384 : sel == 1 ? 16384 : sel == 2 ? 0
			: sel == 3 ? -32768 : $urandom_range(0, 32768) - 16384);
		sel = $urandom_range(9);
		write_reg(REG_SIN_ANGLE, sel == 0 ? -16384 : sel == 1 ? 16384 : sel == 2 ? 0
			: sel == 3 ? 32767 : $urandom_range(0, 32768) - 16384);
		sel = $urandom_range(9);
		write_reg(REG_LEVEL_CENTER, sel == 0 ? 0 : sel == 1 ? 65535 : $urandom_range(65535));
		sel = $urandom_range(9);
		write_reg(REG_WINDOW_WIDTH, sel == 0 ? 1 : sel == 1 ? 131072 : sel == 2 ? 0
			: sel == 3 ? 262143 : $urandom_range(1, 131072));
		write_reg(REG_CHANNEL_MODE, $urandom_range(3));
	endtask

	task automatic test_directed();
		// Reset view: u equals x, row flips against 256.
		send_voxel(0, 0, 0, 1);
		send_voxel(255, 255, 255, 65535);
		send_voxel(255, 255, 255, 65535);   // equal to stored maximum
		send_voxel(255, 255, 0, 100);       // below stored maximum
		send_voxel(10, 20, 30, 0);          // zero never beats a cleared store
		send_voxel(10, 20, 30, 32768);
		send_clear();
		send_voxel(255, 255, 255, 2);       // store was cleared
		wait_idle();
		// Odd sizes give exact half steps; negative cosine makes u fall as z rises.
		write_reg(REG_VIEW_WIDTH, 5);
		write_reg(REG_VIEW_DEPTH, 3);
		write_reg(REG_COS_ANGLE, -16384);
		write_reg(REG_SIN_ANGLE, 8192);
		write_reg(REG_VIEW_HEIGHT, 3);
		write_reg(REG_CHANNEL_MODE, 2);
		for (int z = 0; z < 4; z++) send_voxel(z, 1, z, 4000 + z);
		send_voxel(4, 0, 0, 9000);
		send_voxel(1, 3, 1, 9000);          // row outside the image
		wait_idle();
		// Zero window: at the level maps to 0, above maps to 255.
		write_reg(REG_VIEW_WIDTH, 256);
		write_reg(REG_VIEW_HEIGHT, 300);
		write_reg(REG_VIEW_DEPTH, 256);
		write_reg(REG_COS_ANGLE, 0);
		write_reg(REG_SIN_ANGLE, 16384);
		write_reg(REG_WINDOW_WIDTH, 0);
		write_reg(REG_LEVEL_CENTER, 1000);
		send_voxel(40, 40, 0, 999);
		send_voxel(41, 40, 0, 1000);
		send_voxel(42, 40, 0, 1001);
		send_voxel(43, 0, 0, 1001);         // row above 255 wraps
		wait_idle();
		write_reg(REG_WINDOW_WIDTH, 131072);
		write_reg(REG_LEVEL_CENTER, 65535);
		write_reg(REG_CHANNEL_MODE, 3);
		send_voxel(44, 41, 0, 65535);
		send_voxel(45, 41, 0, 3);
		wait_idle();
	endtask

	// Bursts around a small hotspot so the store sees repeated hits and rising values.
	task automatic test_random_stream(input int tx_pct, input int rx_pct, input int count);
		in_t it;
		int bx, by;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 90 == 0) begin
				wait_idle();
				pick_config();
				bx = $urandom_range(255);
				by = $urandom_range(255);
			end
			if (n == count / 2) begin
				send_clear();
				continue;
			end
			it = in_t'({$urandom(), $urandom()});
			it.op = OP_VOXEL;
			if ($urandom_range(9) < 7) begin
				it.voxel_x = 8'(bx + $urandom_range(7));
				it.voxel_y = 8'(by % (view_h > 0 ? view_h : 1) + $urandom_range(3));
				it.voxel_z = 8'($urandom_range(255));
			end
			send_item(it);
		end
		wait_idle();
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < rx_idle_pct);

	always @(posedge clk) begin
		out_t exp_px;
		if (arst_n && out_valid && !out_stall) begin
			pixels_seen++;
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel %p", out_item));
			end else begin
				exp_px = pending_pixels.pop_front();
				if (out_item.pixel_column !== exp_px.pixel_column)
					report_mismatch($sformatf("column %0d, expected %0d",
						out_item.pixel_column, exp_px.pixel_column));
				if (out_item.pixel_row !== exp_px.pixel_row)
					report_mismatch($sformatf("row %0d, expected %0d",
						out_item.pixel_row, exp_px.pixel_row));
				if (out_item.pixel_channel !== exp_px.pixel_channel)
					report_mismatch($sformatf("channel %0d, expected %0d",
						out_item.pixel_channel, exp_px.pixel_channel));
				if (out_item.pixel_value !== exp_px.pixel_value)
					report_mismatch($sformatf("value %0d, expected %0d",
						out_item.pixel_value, exp_px.pixel_value));
			end
		end
	end

	// The limit covers a full store sweep after a clear item.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			wdog_count <= 0;
		else
			wdog_count <= wdog_count + 1;
		if (wdog_count > WDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		reset_predictor();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_stream(8, 87, 540);
		test_random_stream(87, 8, 540);
		test_random_stream(0, 0, 540);
		repeat (50) @(posedge clk);
		if (pending_pixels.size() != 0)
			report_mismatch($sformatf("%0d pixels never arrived", pending_pixels.size()));
		$display("Sent %0d items (%0d clears) over %0d register writes; %0d pixels checked.",
			items_sent, clears_sent, cfg_writes, pixels_seen);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
